// ===== rtl/msa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the shared-array stacks.
`default_nettype none

package msa_pkg;

  // Sizing of the shared entry array and the stack set
  localparam int TOTAL_ENTRIES = 32;
  localparam int STACK_COUNT   = 4;
  localparam int SLICE         = TOTAL_ENTRIES / STACK_COUNT;

  localparam int ADDR_W = $clog2(TOTAL_ENTRIES);
  localparam int CNT_W  = $clog2(TOTAL_ENTRIES + 1);
  localparam int IDX_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int STK_W  = IDX_W + 1;

  // Field widths on the stream ports
  localparam int ACT_W    = 2;
  localparam int SINDEX_W = 3;
  localparam int KEY_W    = 32;
  localparam int ST_W     = 2;
  localparam int SIZE_W   = 6;

  localparam int IN_DATA_W  = ((SINDEX_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_W + SIZE_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - KEY_W - SIZE_W;

  // Bit positions inside the words
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_KEY_LSB   = SINDEX_W;
  localparam int OUT_POP_LSB  = 0;
  localparam int OUT_SIZE_LSB = KEY_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_NO_ROOM   = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_CHK,
    S_MID,
    S_DN_CHK,
    S_MOVE,
    S_POP_WAIT,
    S_PUSH_WR,
    S_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              clear;
    logic              rd_move;
    logic              wr_move;
    logic              base_inc;
    logic              base_dec;
    logic              push_wr;
    logic              pop_rd;
    logic              out_load;
    logic              dir_down;
    logic [STK_W-1:0]  stk;
    logic [CNT_W-1:0]  cnt;
    status_e           status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_e           act;
    logic              idx_bad;
    logic              tgt_full;
    logic              tgt_empty;
    logic              sel_full;
    logic              sel_can_down;
    logic [CNT_W-1:0]  sel_fill;
    logic [STK_W-1:0]  tgt;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/msa_dpath.sv =====
// Datapath: latched word, stack bases and fills, shared entry array and result register.
`default_nettype none

module msa_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [msa_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic [msa_pkg::ACT_W-1:0]      s_tuser_i,
  input  wire msa_pkg::cmd_t                  cmd_i,
  output msa_pkg::sts_t                       sts_o,
  output logic [msa_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic [msa_pkg::ST_W-1:0]            m_tuser_o
);
  import msa_pkg::*;

  localparam logic [SINDEX_W:0] SC_L     = (SINDEX_W + 1)'(STACK_COUNT);
  localparam logic [CNT_W-1:0]  TOTAL_L  = CNT_W'(TOTAL_ENTRIES);
  localparam logic [CNT_W-1:0]  SIZE_MAX = CNT_W'((2 ** SIZE_W) - 1);

  // Saturate a fill count to the result field width
  function automatic logic [SIZE_W-1:0] size_sat(input logic [CNT_W-1:0] n);
    logic [SIZE_W-1:0] r;
    if (CNT_W > SIZE_W && n > SIZE_MAX) begin
      r = '1;
    end else begin
      r = SIZE_W'(n);
    end
    return r;
  endfunction

  // Latched word
  action_e               act_q;
  logic [SINDEX_W-1:0]   idx_q;
  logic [KEY_W-1:0]      key_q;

  // Stack layout
  logic [CNT_W-1:0]      base_q [STACK_COUNT];
  logic [CNT_W-1:0]      fill_q [STACK_COUNT];
  logic [CNT_W-1:0]      lim    [STACK_COUNT];
  logic [STACK_COUNT-1:0] full;

  // Entry array and its read register
  logic [KEY_W-1:0]      mem_q [TOTAL_ENTRIES];
  logic [KEY_W-1:0]      rd_data_q;
  logic [ADDR_W-1:0]     wr_addr_q;

  // Result register
  status_e               out_status_q;
  logic [KEY_W-1:0]      out_pop_q;
  logic [SIZE_W-1:0]     out_size_q;

  logic [IDX_W-1:0]      tgt;
  logic [IDX_W-1:0]      sel;
  logic [IDX_W-1:0]      sel_below;
  logic                  idx_bad;
  logic [CNT_W-1:0]      sel_base;
  logic [CNT_W-1:0]      sel_fill;
  logic [CNT_W-1:0]      tgt_top;
  logic [ADDR_W-1:0]     mv_src;
  logic [ADDR_W-1:0]     mv_dst;
  logic [ADDR_W-1:0]     push_addr;
  logic [ADDR_W-1:0]     pop_addr;
  logic [ADDR_W-1:0]     rd_addr;

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_e'(s_tuser_i);
      idx_q <= s_tdata_i[IN_IDX_LSB +: SINDEX_W];
      key_q <= s_tdata_i[IN_KEY_LSB +: KEY_W];
    end
  end

  // Room limit and full flag per stack
  for (genvar g = 0; g < STACK_COUNT; g++) begin : g_full
    if (g < STACK_COUNT - 1) begin : g_mid
      assign lim[g] = base_q[g+1];
    end else begin : g_last
      assign lim[g] = TOTAL_L;
    end
    assign full[g] = ({1'b0, base_q[g]} + {1'b0, fill_q[g]}) >= {1'b0, lim[g]};
  end

  // Target and selected-stack views
  assign idx_bad   = {1'b0, idx_q} >= SC_L;
  assign tgt       = idx_q[IDX_W-1:0];
  assign sel       = cmd_i.stk[IDX_W-1:0];
  assign sel_below = sel - 1'b1;
  assign sel_base  = base_q[sel];
  assign sel_fill  = fill_q[sel];
  assign tgt_top   = base_q[tgt] + fill_q[tgt];

  always_comb begin
    sts_o              = '0;
    sts_o.act          = act_q;
    sts_o.idx_bad      = idx_bad;
    sts_o.tgt_full     = full[tgt];
    sts_o.tgt_empty    = (fill_q[tgt] == '0);
    sts_o.sel_full     = full[sel];
    sts_o.sel_can_down = (cmd_i.stk != '0) && !full[sel_below] && (sel_base != '0);
    sts_o.sel_fill     = sel_fill;
    sts_o.tgt          = STK_W'(idx_q);
  end

  // Move addresses: up walks from the top down, down walks from the base up
  always_comb begin
    if (cmd_i.dir_down) begin
      mv_src = ADDR_W'(sel_base + cmd_i.cnt);
      mv_dst = mv_src - 1'b1;
    end else begin
      mv_src = ADDR_W'(sel_base + sel_fill - 1'b1 - cmd_i.cnt);
      mv_dst = mv_src + 1'b1;
    end
  end

  assign push_addr = ADDR_W'(tgt_top);
  assign pop_addr  = ADDR_W'(tgt_top - 1'b1);
  assign rd_addr   = cmd_i.pop_rd ? pop_addr : mv_src;

  // Entry array: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      mem_q[push_addr] <= key_q;
    end else if (cmd_i.wr_move) begin
      mem_q[wr_addr_q] <= rd_data_q;
    end
    if (cmd_i.rd_move || cmd_i.pop_rd) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.rd_move) begin
      wr_addr_q <= mv_dst;
    end
  end

  // Bases and fills
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        base_q[i] <= CNT_W'(i * SLICE);
        fill_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        base_q[i] <= CNT_W'(i * SLICE);
        fill_q[i] <= '0;
      end
    end else begin
      if (cmd_i.base_inc) begin
        base_q[sel] <= sel_base + 1'b1;
      end
      if (cmd_i.base_dec) begin
        base_q[sel] <= sel_base - 1'b1;
      end
      if (cmd_i.push_wr) begin
        fill_q[tgt] <= fill_q[tgt] + 1'b1;
      end
      if (cmd_i.pop_rd) begin
        fill_q[tgt] <= fill_q[tgt] - 1'b1;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.status;
      out_pop_q    <= (cmd_i.status == ST_OK && act_q == ACT_POP) ? rd_data_q : '0;
      out_size_q   <= (act_q == ACT_CLEAR || idx_bad) ? '0 : size_sat(fill_q[tgt]);
    end
  end

  assign m_tdata_o = {{OUT_PAD_W{1'b0}}, out_size_q, out_pop_q};
  assign m_tuser_o = out_status_q;

endmodule

`default_nettype wire

// ===== rtl/msa_ctrl.sv =====
// Controller: sequences decode, shift passes, push/pop and the result handoff.
`default_nettype none

module msa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  input  wire logic          m_ready_i,
  input  wire msa_pkg::sts_t sts_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  output msa_pkg::cmd_t      cmd_o
);
  import msa_pkg::*;

  state_e            state_q, state_d;
  logic [STK_W-1:0]  stk_q, stk_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              dir_q, dir_d;
  status_e           status_q, status_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free;
  logic              move_last;

  assign out_free  = !out_vld_q || m_ready_i;
  assign move_last = (cnt_q == sts_i.sel_fill);

  // Next state
  always_comb begin
    state_d  = state_q;
    stk_d    = stk_q;
    cnt_d    = cnt_q;
    dir_d    = dir_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.act == ACT_CLEAR) begin
          status_d = ST_OK;
          state_d  = S_RESP;
        end else if (sts_i.idx_bad) begin
          status_d = ST_BAD_INDEX;
          state_d  = S_RESP;
        end else if (sts_i.act == ACT_PUSH) begin
          if (sts_i.tgt_full) begin
            stk_d   = STK_W'(STACK_COUNT - 1);
            state_d = S_UP_CHK;
          end else begin
            state_d = S_PUSH_WR;
          end
        end else if (sts_i.act == ACT_POP) begin
          if (sts_i.tgt_empty) begin
            status_d = ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            status_d = ST_OK;
            state_d  = S_POP_WAIT;
          end
        end else begin
          status_d = ST_OK;
          state_d  = S_RESP;
        end
      end
      // Right pass: last stack down to the one after the target
      S_UP_CHK: begin
        if (stk_q <= sts_i.tgt) begin
          state_d = S_MID;
        end else if (!sts_i.sel_full) begin
          dir_d   = 1'b0;
          cnt_d   = '0;
          state_d = S_MOVE;
        end else begin
          stk_d = stk_q - 1'b1;
        end
      end
      S_MID: begin
        if (sts_i.tgt_full) begin
          stk_d   = STK_W'(1);
          state_d = S_DN_CHK;
        end else begin
          state_d = S_PUSH_WR;
        end
      end
      // Left pass: stack 1 up through the target
      S_DN_CHK: begin
        if (stk_q > sts_i.tgt) begin
          state_d = S_PUSH_WR;
        end else if (sts_i.sel_can_down) begin
          dir_d   = 1'b1;
          cnt_d   = '0;
          state_d = S_MOVE;
        end else begin
          stk_d = stk_q + 1'b1;
        end
      end
      // One entry read per cycle, written in the cycle after
      S_MOVE: begin
        if (move_last) begin
          if (dir_q) begin
            stk_d   = stk_q + 1'b1;
            state_d = S_DN_CHK;
          end else begin
            stk_d   = stk_q - 1'b1;
            state_d = S_UP_CHK;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_POP_WAIT: begin
        state_d = S_RESP;
      end
      S_PUSH_WR: begin
        status_d = sts_i.tgt_full ? ST_NO_ROOM : ST_OK;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.stk      = stk_q;
    cmd_o.cnt      = cnt_q;
    cmd_o.dir_down = dir_q;
    cmd_o.status   = status_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = s_valid_i;
      end
      S_DECODE: begin
        cmd_o.clear  = (sts_i.act == ACT_CLEAR);
        cmd_o.pop_rd = (sts_i.act == ACT_POP) && !sts_i.idx_bad && !sts_i.tgt_empty;
      end
      S_MOVE: begin
        cmd_o.rd_move  = !move_last;
        cmd_o.wr_move  = (cnt_q != '0);
        cmd_o.base_inc = move_last && !dir_q;
        cmd_o.base_dec = move_last && dir_q;
      end
      S_PUSH_WR: begin
        cmd_o.push_wr = !sts_i.tgt_full;
      end
      S_RESP: begin
        cmd_o.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stk_q     <= '0;
      cnt_q     <= '0;
      dir_q     <= 1'b0;
      status_q  <= ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      stk_q     <= stk_d;
      cnt_q     <= cnt_d;
      dir_q     <= dir_d;
      status_q  <= status_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_vld_q;

endmodule

`default_nettype wire

// ===== rtl/multiple_stacks_shared_array_core.sv =====
// Top level: several stacks sharing one entry array, with shifting on overflow.
//
//   channel   dir  tdata (low bit up)                    tuser
//   s_axis    in   stack_index[2:0], key_value[34:3]     action
//   m_axis    out  popped_value[31:0], stack_size[37:32] status
//
// One word at a time: each word is decoded, carried out and its result loaded
// before the next word is accepted. A push onto a full stack visits each stack
// from the last down to the one after the target and shifts up each one that is
// not full; if the target is still full, it visits stack 1 up through the
// target and shifts down each one whose neighbour below has room.
// A result waiting on m_axis does not block accepting the next word.
// Reset restores the initial layout at once; stored entries are not cleared.
`default_nettype none

module multiple_stacks_shared_array_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // stack_index, key_value
  input  wire logic [msa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action
  input  wire logic [msa_pkg::ACT_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // popped_value, stack_size
  output logic [msa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status
  output logic [msa_pkg::ST_W-1:0]             m_axis_tuser
);
  import msa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  msa_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/msa_chk.sv =====
// Port-level checks for the shared-array stacks, bound to the top level.
`default_nettype none

module msa_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [msa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [msa_pkg::ST_W-1:0]        m_axis_tuser
);
  import msa_pkg::*;

  logic [KEY_W-1:0]  pop_v;
  logic [SIZE_W-1:0] size_v;

  assign pop_v  = m_axis_tdata[OUT_POP_LSB +: KEY_W];
  assign size_v = m_axis_tdata[OUT_SIZE_LSB +: SIZE_W];

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Only a good pop carries a value
  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> pop_v == '0)
    else $error("value returned with an error status");

  // Bad index and empty pop report size zero
  a_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_BAD_INDEX || m_axis_tuser == ST_EMPTY)
      |-> size_v == '0)
    else $error("nonzero size with bad index or empty stack");

  // The block is busy in the cycle after it takes a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while previous one in flight");

endmodule

bind multiple_stacks_shared_array_core msa_chk u_msa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
